### design/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define STQ_ASSERT_ALWAYS(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("stq assertion failed");

// Antecedent implies consequent in the same cycle.
`define STQ_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("stq assertion failed");

// Antecedent implies consequent in the next cycle.
`define STQ_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("stq assertion failed");

`endif

### design/stq_pkg.sv
`default_nettype none
package stq_pkg;

   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int MAX_RESULTS     = 16;

   // request codes
   localparam logic [1:0] REQ_ADD     = 2'd0;
   localparam logic [1:0] REQ_CHECK   = 2'd1;
   localparam logic [1:0] REQ_TIMEOUT = 2'd2;

   localparam logic [19:0] USEC_PER_SEC = 20'd1000000;
   localparam logic [19:0] USEC_MAX     = 20'd999999;
   localparam logic [9:0]  MS_PER_SEC   = 10'd1000;
   localparam logic [9:0]  USEC_PER_MS  = 10'd1000;

   // x / 1000 == (x * RECIP_1000) >> RECIP_SHIFT for every 32-bit x
   localparam logic [28:0] RECIP_1000  = 29'd274877907;
   localparam int          RECIP_SHIFT = 38;
   localparam int          QUOT_W      = 23;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [31:0] now_sec;
      logic [19:0] now_usec;
      logic [31:0] delay_ms;
      logic [7:0]  handler_id;
      logic [31:0] cookie;
   } stq_req_type;

   typedef struct packed {
      logic        fired;
      logic [7:0]  handler_out;
      logic [31:0] cookie_out;
      logic        last;
      logic        queue_empty;
      logic        add_dropped;
      logic [31:0] wait_sec;
      logic [19:0] wait_usec;
   } stq_rsp_type;

   typedef struct packed {
      logic [31:0] sec;
      logic [19:0] usec;
      logic [7:0]  handler;
      logic [31:0] cookie;
   } stq_entry_type;

   // deadline a strictly before deadline b, serial-number compare on seconds
   function automatic logic deadline_lt(input logic [31:0] sa, input logic [19:0] ua,
                                        input logic [31:0] sb, input logic [19:0] ub);
      logic [31:0] diff;
      diff = sa - sb;
      if (sa == sb) return ua < ub;
      return diff[31];
   endfunction

   // deadline a at or before deadline b
   function automatic logic deadline_le(input logic [31:0] sa, input logic [19:0] ua,
                                        input logic [31:0] sb, input logic [19:0] ub);
      logic [31:0] diff;
      diff = sa - sb;
      if (sa == sb) return ua <= ub;
      return diff[31];
   endfunction

endpackage
`default_nettype wire

### design/stq_entry_ram.sv
`default_nettype none
module stq_entry_ram
   import stq_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  wire                             clock,
   input  wire                             wr_en,
   input  wire [$clog2(QUEUE_DEPTH)-1:0]   wr_addr,
   input  stq_entry_type                   wr_data,
   input  wire                             rd_en,
   input  wire [$clog2(QUEUE_DEPTH)-1:0]   rd_addr,
   output stq_entry_type                   rd_data
);

   stq_entry_type mem_ff [QUEUE_DEPTH];
   stq_entry_type rd_data_ff;

   // one write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // one registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

### design/sorted_deadline_timer_queue.sv
// Sorted timer queue, entries kept in one single-port-read RAM in deadline order.
// Add: deadline math (S_DIV1 to S_DIV4), a read and a compare per entry scanned to
// find the slot, a read and a write per entry shifted, then S_PUT, unless full.
// Check: a result word per fired entry (at most MAX_RESULTS), else one last word.
// Timeout: head read. One request at a time; busy is high until the last word.
// Synchronous reset empties the queue; results cannot be stalled by the receiver.
`default_nettype none
`include "assert_macros.svh"
module sorted_deadline_timer_queue
   import stq_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          start,
   output logic         busy,
   input  stq_req_type  req_word,
   output logic         rsp_strobe,
   output stq_rsp_type  rsp_word
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int IW = $clog2(QUEUE_DEPTH);
   localparam int NW = $clog2(MAX_RESULTS + 1);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_DIV1     = 4'd1;
   localparam logic [3:0] S_DIV2     = 4'd2;
   localparam logic [3:0] S_DIV3     = 4'd3;
   localparam logic [3:0] S_DIV4     = 4'd4;
   localparam logic [3:0] S_FIND_RD  = 4'd5;
   localparam logic [3:0] S_FIND_CMP = 4'd6;
   localparam logic [3:0] S_SHIFT_RD = 4'd7;
   localparam logic [3:0] S_SHIFT_WR = 4'd8;
   localparam logic [3:0] S_PUT      = 4'd9;
   localparam logic [3:0] S_CHK_RD   = 4'd10;
   localparam logic [3:0] S_CHK_EV   = 4'd11;
   localparam logic [3:0] S_CHK_END  = 4'd12;
   localparam logic [3:0] S_TMO_RD   = 4'd13;
   localparam logic [3:0] S_TMO_EV   = 4'd14;

   logic [3:0]        state_ff, state_in;
   stq_req_type       req_ff, req_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     idx_ff, idx_in;
   logic [CW-1:0]     keep_ff, keep_in;
   logic [CW-1:0]     pos_ff, pos_in;
   logic [NW-1:0]     nfire_ff, nfire_in;
   logic              pend_vld_ff, pend_vld_in;
   stq_entry_type     pend_ff, pend_in;
   logic [60:0]       prod_ff, prod_in;
   logic [QUOT_W-1:0] quot_ff, quot_in;
   logic [9:0]        rem_ff, rem_in;
   logic [20:0]       usum_ff, usum_in;
   stq_entry_type     new_ff, new_in;
   stq_rsp_type       rsp_ff, rsp_in;
   logic              rsp_strobe_ff, rsp_strobe_in;

   logic              wr_en, rd_en;
   logic [IW-1:0]     wr_addr, rd_addr;
   stq_entry_type     wr_data, rd_data;

   logic              due, ins_here;
   logic [31:0]       t_sec;
   logic [20:0]       t_usec;

   stq_entry_ram #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // compares against the word just read
   assign due      = deadline_le(rd_data.sec, rd_data.usec, req_ff.now_sec, req_ff.now_usec);
   assign ins_here = deadline_lt(new_ff.sec, new_ff.usec, rd_data.sec, rd_data.usec);

   // sequencer
   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      keep_in       = keep_ff;
      pos_in        = pos_ff;
      nfire_in      = nfire_ff;
      pend_vld_in   = pend_vld_ff;
      pend_in       = pend_ff;
      prod_in       = prod_ff;
      quot_in       = quot_ff;
      rem_in        = rem_ff;
      usum_in       = usum_ff;
      new_in        = new_ff;
      rsp_in        = rsp_ff;
      rsp_strobe_in = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = idx_ff[IW-1:0];
      wr_data       = rd_data;
      rd_en         = 1'b0;
      rd_addr       = idx_ff[IW-1:0];
      t_sec         = '0;
      t_usec        = '0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in = req_word;
               if (req_word.now_usec > USEC_MAX) req_in.now_usec = USEC_MAX;
               rsp_in   = '0;
               idx_in   = '0;
               keep_in  = '0;
               nfire_in = '0;
               pend_vld_in = 1'b0;
               case (req_word.req_type)
                  REQ_ADD: begin
                     if (count_ff >= CW'(QUEUE_DEPTH)) begin
                        rsp_in.add_dropped = 1'b1;
                        rsp_in.last        = 1'b1;
                        rsp_strobe_in      = 1'b1;
                     end else begin
                        state_in = S_DIV1;
                     end
                  end
                  REQ_CHECK:   state_in = S_CHK_RD;
                  REQ_TIMEOUT: begin
                     if (count_ff == '0) begin
                        rsp_in.queue_empty = 1'b1;
                        rsp_in.last        = 1'b1;
                        rsp_strobe_in      = 1'b1;
                     end else begin
                        state_in = S_TMO_RD;
                     end
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end

         // delay_ms / 1000 by reciprocal
         S_DIV1: begin
            prod_in  = req_ff.delay_ms * RECIP_1000;
            state_in = S_DIV2;
         end
         S_DIV2: begin
            quot_in  = prod_ff[RECIP_SHIFT +: QUOT_W];
            state_in = S_DIV3;
         end
         S_DIV3: begin
            rem_in   = 10'(req_ff.delay_ms - 32'(quot_ff) * 32'(MS_PER_SEC));
            state_in = S_DIV4;
         end
         // microseconds sum, then normalize into the new entry
         S_DIV4: begin
            usum_in  = 21'(req_ff.now_usec) + 21'(rem_ff) * 21'(USEC_PER_MS);
            state_in = S_FIND_RD;
            // normalize in the next state: FIND_RD does it on its pass with idx_ff at zero
         end

         S_FIND_RD: begin
            if (idx_ff == '0) begin
               // first pass: finish the deadline from the registered sum
               if (usum_ff >= 21'(USEC_PER_SEC)) begin
                  new_in.usec = 20'(usum_ff - 21'(USEC_PER_SEC));
                  new_in.sec  = req_ff.now_sec + 32'(quot_ff) + 32'd1;
               end else begin
                  new_in.usec = usum_ff[19:0];
                  new_in.sec  = req_ff.now_sec + 32'(quot_ff);
               end
               new_in.handler = req_ff.handler_id;
               new_in.cookie  = req_ff.cookie;
            end
            if (idx_ff == count_ff) begin
               pos_in   = count_ff;
               state_in = S_SHIFT_RD;
            end else begin
               rd_en    = 1'b1;
               state_in = S_FIND_CMP;
            end
         end
         S_FIND_CMP: begin
            if (ins_here) begin
               pos_in   = idx_ff;
               idx_in   = count_ff;
               state_in = S_SHIFT_RD;
            end else begin
               idx_in   = idx_ff + CW'(1);
               state_in = S_FIND_RD;
            end
         end

         // move entries up by one, from the tail down to the slot
         S_SHIFT_RD: begin
            if (idx_ff == pos_ff) begin
               state_in = S_PUT;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = IW'(idx_ff - CW'(1));
               state_in = S_SHIFT_WR;
            end
         end
         S_SHIFT_WR: begin
            wr_en    = 1'b1;
            idx_in   = idx_ff - CW'(1);
            state_in = S_SHIFT_RD;
         end
         S_PUT: begin
            wr_en         = 1'b1;
            wr_addr       = pos_ff[IW-1:0];
            wr_data       = new_ff;
            count_in      = count_ff + CW'(1);
            rsp_in.last   = 1'b1;
            rsp_strobe_in = 1'b1;
            state_in      = S_IDLE;
         end

         // expiry scan with in-place compaction
         S_CHK_RD: begin
            if (idx_ff == count_ff) begin
               state_in = S_CHK_END;
            end else begin
               rd_en    = 1'b1;
               state_in = S_CHK_EV;
            end
         end
         S_CHK_EV: begin
            if (due && nfire_ff < NW'(MAX_RESULTS)) begin
               if (pend_vld_ff) begin
                  rsp_in.fired       = 1'b1;
                  rsp_in.handler_out = pend_ff.handler;
                  rsp_in.cookie_out  = pend_ff.cookie;
                  rsp_strobe_in      = 1'b1;
               end
               pend_in     = rd_data;
               pend_vld_in = 1'b1;
               nfire_in    = nfire_ff + NW'(1);
            end else begin
               wr_en   = 1'b1;
               wr_addr = keep_ff[IW-1:0];
               keep_in = keep_ff + CW'(1);
            end
            idx_in   = idx_ff + CW'(1);
            state_in = S_CHK_RD;
         end
         S_CHK_END: begin
            count_in           = keep_ff;
            rsp_in.fired       = pend_vld_ff;
            rsp_in.handler_out = pend_vld_ff ? pend_ff.handler : 8'd0;
            rsp_in.cookie_out  = pend_vld_ff ? pend_ff.cookie : 32'd0;
            rsp_in.last        = 1'b1;
            rsp_strobe_in      = 1'b1;
            state_in           = S_IDLE;
         end

         // time left until the head entry
         S_TMO_RD: begin
            rd_en    = 1'b1;
            rd_addr  = '0;
            state_in = S_TMO_EV;
         end
         S_TMO_EV: begin
            if (!due) begin
               t_sec = rd_data.sec - req_ff.now_sec;
               if (rd_data.usec < req_ff.now_usec) begin
                  t_usec = 21'(USEC_PER_SEC) + 21'(rd_data.usec) - 21'(req_ff.now_usec);
                  t_sec  = t_sec - 32'd1;
               end else begin
                  t_usec = 21'(rd_data.usec) - 21'(req_ff.now_usec);
               end
            end
            rsp_in.wait_sec  = t_sec;
            rsp_in.wait_usec = t_usec[19:0];
            rsp_in.last      = 1'b1;
            rsp_strobe_in    = 1'b1;
            state_in         = S_IDLE;
         end

         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
         pend_vld_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
         pend_vld_ff   <= pend_vld_in;
      end
   end

   // payload and working registers
   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      idx_ff   <= idx_in;
      keep_ff  <= keep_in;
      pos_ff   <= pos_in;
      nfire_ff <= nfire_in;
      pend_ff  <= pend_in;
      prod_ff  <= prod_in;
      quot_ff  <= quot_in;
      rem_ff   <= rem_in;
      usum_ff  <= usum_in;
      new_ff   <= new_in;
      rsp_ff   <= rsp_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_ff;

   `STQ_ASSERT_ALWAYS(a_count_range, count_ff <= CW'(QUEUE_DEPTH))
   `STQ_ASSERT_IMPL(a_last_ends_request, rsp_strobe_ff && rsp_ff.last, state_ff == S_IDLE)
   `STQ_ASSERT_IMPL(a_mid_word_in_scan, rsp_strobe_ff && !rsp_ff.last, state_ff == S_CHK_RD)
   `STQ_ASSERT_NEXT(a_put_grows, state_ff == S_PUT, count_ff == $past(count_ff) + CW'(1))

endmodule
`default_nettype wire

### verif/sorted_deadline_timer_queue_checker.sv
`timescale 1ns / 100ps
`default_nettype none
module sorted_deadline_timer_queue_checker
   import stq_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          start,
   input  wire          busy,
   input  stq_req_type  req_word,
   input  wire          rsp_strobe,
   input  stq_rsp_type  rsp_word,
   output int           fail_count,
   output int           pending_count
);

   // shadow copy of the queue contents
   stq_entry_type timers[QUEUE_DEPTH];
   int            timer_count;
   stq_rsp_type   expected_words[$];

   // serial-number compare: -1 before, 0 equal, 1 after
   function automatic int order_of(input logic [31:0] sa, input logic [19:0] ua,
                                   input logic [31:0] sb, input logic [19:0] ub);
      logic [31:0] diff;
      diff = sa - sb;
      if (sa == sb) return (ua < ub) ? -1 : ((ua > ub) ? 1 : 0);
      return diff[31] ? -1 : 1;
   endfunction

   task automatic report_mismatch(input string what, input stq_rsp_type got,
                                  input stq_rsp_type want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   // predict the words caused by one accepted request
   task automatic predict_words(input stq_req_type rq);
      stq_rsp_type w;
      logic [19:0] nu;
      logic [31:0] sec, rem_sec;
      logic [31:0] us;
      stq_entry_type kept[QUEUE_DEPTH];
      int pos, keep, fired_n;
      w = '0;
      w.last = 1'b1;
      nu = (rq.now_usec > USEC_MAX) ? USEC_MAX : rq.now_usec;
      case (rq.req_type)
         REQ_ADD: begin
            if (timer_count >= QUEUE_DEPTH) begin
               w.add_dropped = 1'b1;
            end else begin
               us = 32'(nu) + (rq.delay_ms % 1000) * 1000;
               sec = rq.now_sec + rq.delay_ms / 1000 + us / 1000000;
               us = us % 1000000;
               pos = timer_count;
               for (int i = 0; i < timer_count; i++)
                  if (order_of(sec, us[19:0], timers[i].sec, timers[i].usec) < 0) begin
                     pos = i;
                     break;
                  end
               for (int i = timer_count; i > pos; i--) timers[i] = timers[i-1];
               timers[pos] = '{sec, us[19:0], rq.handler_id, rq.cookie};
               timer_count++;
            end
            expected_words.push_back(w);
         end
         REQ_CHECK: begin
            keep = 0;
            fired_n = 0;
            for (int i = 0; i < timer_count; i++) begin
               if (order_of(timers[i].sec, timers[i].usec, rq.now_sec, nu) <= 0
                   && fired_n < MAX_RESULTS) begin
                  w = '0;
                  w.fired = 1'b1;
                  w.handler_out = timers[i].handler;
                  w.cookie_out = timers[i].cookie;
                  expected_words.push_back(w);
                  fired_n++;
               end else begin
                  kept[keep] = timers[i];
                  keep++;
               end
            end
            for (int i = 0; i < keep; i++) timers[i] = kept[i];
            timer_count = keep;
            if (fired_n == 0) begin
               w = '0;
               w.last = 1'b1;
               expected_words.push_back(w);
            end else begin
               w = expected_words.pop_back();
               w.last = 1'b1;
               expected_words.push_back(w);
            end
         end
         REQ_TIMEOUT: begin
            if (timer_count == 0) begin
               w.queue_empty = 1'b1;
            end else if (order_of(timers[0].sec, timers[0].usec, rq.now_sec, nu) > 0) begin
               rem_sec = timers[0].sec - rq.now_sec;
               if (timers[0].usec < nu) begin
                  w.wait_usec = USEC_PER_SEC + timers[0].usec - nu;
                  rem_sec = rem_sec - 1;
               end else begin
                  w.wait_usec = timers[0].usec - nu;
               end
               w.wait_sec = rem_sec;
            end
            expected_words.push_back(w);
         end
         default: ;
      endcase
   endtask

   // watch both channels at the rising edge
   always @(posedge clock) begin
      stq_rsp_type want;
      if (reset) begin
         timer_count = 0;
         expected_words.delete();
         fail_count = 0;
      end else begin
         if (rsp_strobe) begin
            if (expected_words.size() == 0) begin
               report_mismatch("unexpected word", rsp_word, '0);
            end else begin
               want = expected_words.pop_front();
               if (rsp_word.fired !== want.fired) report_mismatch("fired", rsp_word, want);
               if (rsp_word.handler_out !== want.handler_out)
                  report_mismatch("handler_out", rsp_word, want);
               if (rsp_word.cookie_out !== want.cookie_out)
                  report_mismatch("cookie_out", rsp_word, want);
               if (rsp_word.last !== want.last) report_mismatch("last", rsp_word, want);
               if (rsp_word.queue_empty !== want.queue_empty)
                  report_mismatch("queue_empty", rsp_word, want);
               if (rsp_word.add_dropped !== want.add_dropped)
                  report_mismatch("add_dropped", rsp_word, want);
               if (rsp_word.wait_sec !== want.wait_sec)
                  report_mismatch("wait_sec", rsp_word, want);
               if (rsp_word.wait_usec !== want.wait_usec)
                  report_mismatch("wait_usec", rsp_word, want);
            end
         end
         if (start && !busy) predict_words(req_word);
      end
      pending_count = expected_words.size();
   end

endmodule
`default_nettype wire

### verif/sorted_deadline_timer_queue_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module sorted_deadline_timer_queue_tb;
   import stq_pkg::*;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   stq_req_type req_word;
   logic        rsp_strobe;
   stq_rsp_type rsp_word;
   int          fail_count;
   int          pending_count;

   logic [31:0] base_sec;

   sorted_deadline_timer_queue uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_word(req_word), .rsp_strobe(rsp_strobe), .rsp_word(rsp_word)
   );

   sorted_deadline_timer_queue_checker chk (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_word(req_word), .rsp_strobe(rsp_strobe), .rsp_word(rsp_word),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // hold start high until the word is taken and busy is low, then drop it
   task automatic send_word(input logic [1:0] kind, input logic [31:0] sec,
                            input logic [19:0] usec, input logic [31:0] ms,
                            input logic [7:0] hid, input logic [31:0] ck);
      @(negedge clock);
      req_word <= '{kind, sec, usec, ms, hid, ck};
      start <= 1'b1;
      do @(posedge clock); while (busy);
      @(negedge clock);
      start <= 1'b0;
   endtask

   task automatic idle_cycles(input int n);
      repeat (n) @(negedge clock);
   endtask

   // random microseconds, now and then at or beyond USEC_MAX
   function automatic logic [19:0] pick_usec();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return 20'hFFFFF;
      if (r == 1) return 20'($urandom_range(1000000, 1048575));
      if (r == 2) return USEC_MAX;
      return 20'($urandom_range(0, 999999));
   endfunction

   function automatic logic [31:0] pick_delay();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return $urandom();
      if (r == 1) return 32'hFFFFFFFF;
      if (r == 2) return 0;
      return $urandom_range(0, 5000);
   endfunction

   initial begin
      int burst;
      int r;
      logic [1:0] kind;
      reset = 1'b1;
      start = 1'b0;
      req_word = '0;
      base_sec = 32'hFFFFFFF0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty timeout, empty check, extremes, wrap, fill past full
      send_word(REQ_TIMEOUT, 0, 0, 0, 0, 0);
      send_word(REQ_CHECK, 0, 0, 0, 0, 0);
      send_word(REQ_ADD, 32'hFFFFFFFF, USEC_MAX, 32'hFFFFFFFF, 8'hFF, 32'hFFFFFFFF);
      send_word(REQ_ADD, 32'hFFFFFFFF, 20'hFFFFF, 999, 8'h00, 32'h0);
      send_word(REQ_ADD, 0, 0, 0, 8'hA5, 32'h5A5A5A5A);
      send_word(REQ_ADD, 0, 0, 0, 8'h5A, 32'hA5A5A5A5);
      send_word(REQ_TIMEOUT, 32'hFFFFFFFE, 20'd500000, 0, 0, 0);
      send_word(REQ_TIMEOUT, 5, 0, 0, 0, 0);
      send_word(2'd3, 1, 1, 1, 1, 1);
      for (int i = 0; i < 14; i++)
         send_word(REQ_ADD, 100, 20'(i * 1000), 32'(i % 3), 8'(i), 32'(i));
      send_word(REQ_ADD, 100, 0, 0, 8'h11, 32'h11);
      send_word(REQ_CHECK, 32'h7FFFFFFF, 0, 0, 0, 0);
      send_word(REQ_CHECK, 32'h80000100, USEC_MAX, 0, 0, 0);

      // random bursts: mostly adds and checks near a drifting time base
      for (int n = 0; n < 300; ) begin
         burst = $urandom_range(1, 12);
         for (int b = 0; b < burst; b++) begin
            r = $urandom_range(0, 99);
            kind = (r < 50) ? REQ_ADD : (r < 78) ? REQ_CHECK : (r < 97) ? REQ_TIMEOUT : 2'd3;
            base_sec = base_sec + 32'($urandom_range(0, 2));
            if ($urandom_range(0, 19) == 0)
               send_word(kind, $urandom(), pick_usec(), pick_delay(),
                         8'($urandom()), $urandom());
            else
               send_word(kind, base_sec, pick_usec(), pick_delay(),
                         8'($urandom()), $urandom());
            if (kind != 2'd3) n++;
         end
         if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 40));
      end
      // drain whatever is left
      send_word(REQ_CHECK, base_sec + 32'h7FFFFFF0, USEC_MAX, 0, 0, 0);
      send_word(REQ_CHECK, base_sec + 32'h7FFFFFF0, USEC_MAX, 0, 0, 0);

      while (pending_count != 0 || busy) @(negedge clock);
      idle_cycles(100);
      if (fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #2000000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
`default_nettype wire

### files.f
+incdir+design
design/stq_pkg.sv
design/stq_entry_ram.sv
design/sorted_deadline_timer_queue.sv
verif/sorted_deadline_timer_queue_checker.sv
verif/sorted_deadline_timer_queue_tb.sv
